// ----- hw/rtl/sfr_pkg.sv -----
// Shared constants and types for the serial frame receiver.
package sfr_pkg;

  localparam int MAX_DATA = 32;
  localparam int ADDR_W   = $clog2(MAX_DATA);
  localparam int CNT_W    = $clog2(MAX_DATA + 1);
  localparam int POS_W    = $clog2(MAX_DATA + 8);
  localparam int LEN_W    = 6;
  localparam int IDX_W    = 5;
  localparam int TICK_W   = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'hAA;
  localparam logic [7:0] MIN_LEN    = 8'd2;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam logic [7:0]        OWN_ADDR_RST = 8'd34;
  localparam logic [TICK_W-1:0] TIMEOUT_RST  = 10'd100;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b1;

  // Input commands.
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Parser positions with a meaning of their own; data starts at POS_DATA.
  localparam logic [POS_W-1:0] POS_HUNT   = 6'd0;
  localparam logic [POS_W-1:0] POS_HDR2   = 6'd1;
  localparam logic [POS_W-1:0] POS_LEN    = 6'd2;
  localparam logic [POS_W-1:0] POS_ADDR   = 6'd3;
  localparam logic [POS_W-1:0] POS_MODE   = 6'd4;
  localparam logic [POS_W-1:0] POS_OFFSET = 6'd5;
  localparam logic [POS_W-1:0] POS_DATA   = 6'd6;

  typedef enum logic {
    ST_RECV,
    ST_REPLAY
  } state_t;

endpackage

// ----- hw/rtl/serial_frame_receiver_unit.sv -----
// Serial frame receiver: header hunt, checksum and replay of buffered data.
// Each input request (byte or tick) is accepted whenever the unit is receiving.
// After a good checksum byte, results leave at one per cycle from the data
// buffer while the output is free, passing the read register and the output
// register (a frame without data loads the output register directly); the input
// stalls until the final result is loaded. Reset (rst_n low, synchronous)
// restores the header hunt and register defaults; the buffer is not cleared.
module serial_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_frame_length,
  output logic [7:0]  out_frame_mode,
  output logic [7:0]  out_frame_offset,
  output logic        out_has_data,
  output logic [4:0]  out_byte_index,
  output logic [7:0]  out_payload_byte,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW  = sfr_pkg::ADDR_W;
  localparam int CW  = sfr_pkg::CNT_W;
  localparam int PW  = sfr_pkg::POS_W;
  localparam int LW  = sfr_pkg::LEN_W;
  localparam int TW  = sfr_pkg::TICK_W;

  // Configuration
  logic [7:0]    own_addr_r;
  logic [TW-1:0] timeout_r;

  // Parser state
  sfr_pkg::state_t state_r, state_nxt;
  logic [PW-1:0] pos_r, pos_nxt, pos_eff;
  logic [LW-1:0] len_r, len_nxt;
  logic [7:0]    mode_r, mode_nxt;
  logic [7:0]    offset_r, offset_nxt;
  logic [15:0]   sum_r, sum_nxt;
  logic [7:0]    sum_lo_r, sum_lo_nxt;
  logic [TW-1:0] elapsed_r, elapsed_nxt;

  // Replay
  logic [CW-1:0] iss_r, iss_nxt;
  logic [CW-1:0] emit_r, emit_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic [7:0]    rd_data_r;

  // Output register
  logic          out_valid_r, out_valid_nxt;
  logic [LW-1:0] o_len_r, o_len_nxt;
  logic [7:0]    o_mode_r, o_mode_nxt;
  logic [7:0]    o_offset_r, o_offset_nxt;
  logic          o_has_r, o_has_nxt;
  logic [4:0]    o_idx_r, o_idx_nxt;
  logic [7:0]    o_byte_r, o_byte_nxt;
  logic          o_last_r, o_last_nxt;

  // Data buffer
  logic [7:0]    buf_mem [sfr_pkg::MAX_DATA];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;

  logic          in_fire;
  logic          slot_free;
  logic          consume;
  logic [CW-1:0] data_cnt;
  logic [PW-1:0] k;
  logic [15:0]   got_sum;

  assign in_ready  = (state_r == sfr_pkg::ST_RECV);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign data_cnt  = CW'(len_r - LW'(2));
  assign k         = pos_eff - sfr_pkg::POS_DATA;
  assign got_sum   = {in_rx_byte, sum_lo_r};

  // A stale partial frame is dropped before the new byte is looked at.
  assign pos_eff = ((pos_r != sfr_pkg::POS_HUNT) && (elapsed_r >= timeout_r))
                   ? sfr_pkg::POS_HUNT : pos_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    mode_nxt      = mode_r;
    offset_nxt    = offset_r;
    sum_nxt       = sum_r;
    sum_lo_nxt    = sum_lo_r;
    elapsed_nxt   = elapsed_r;
    iss_nxt       = iss_r;
    emit_nxt      = emit_r;
    rd_pend_nxt   = rd_pend_r;
    wr_en         = 1'b0;
    wr_addr       = k[AW-1:0];
    rd_en         = 1'b0;
    consume       = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    o_len_nxt     = o_len_r;
    o_mode_nxt    = o_mode_r;
    o_offset_nxt  = o_offset_r;
    o_has_nxt     = o_has_r;
    o_idx_nxt     = o_idx_r;
    o_byte_nxt    = o_byte_r;
    o_last_nxt    = o_last_r;

    case (state_r)
      sfr_pkg::ST_RECV: begin
        if (in_fire) begin
          if (in_command == sfr_pkg::CMD_TICK) begin
            if (elapsed_r != sfr_pkg::TICK_MAX) begin
              elapsed_nxt = elapsed_r + TW'(1);
            end
          end else begin
            pos_nxt = pos_eff;
            case (pos_eff)
              sfr_pkg::POS_HUNT: begin
                if (in_rx_byte == sfr_pkg::HDR_FIRST) begin
                  elapsed_nxt = '0;
                  pos_nxt     = sfr_pkg::POS_HDR2;
                end
              end
              sfr_pkg::POS_HDR2: begin
                pos_nxt = (in_rx_byte == sfr_pkg::HDR_SECOND) ? sfr_pkg::POS_LEN
                                                              : sfr_pkg::POS_HUNT;
              end
              sfr_pkg::POS_LEN: begin
                if ((in_rx_byte < sfr_pkg::MIN_LEN) ||
                    ((in_rx_byte - sfr_pkg::MIN_LEN) > 8'(sfr_pkg::MAX_DATA))) begin
                  pos_nxt = sfr_pkg::POS_HUNT;
                end else begin
                  len_nxt = in_rx_byte[LW-1:0];
                  sum_nxt = {8'h00, in_rx_byte};
                  pos_nxt = sfr_pkg::POS_ADDR;
                end
              end
              sfr_pkg::POS_ADDR: begin
                if (in_rx_byte != own_addr_r) begin
                  pos_nxt = sfr_pkg::POS_HUNT;
                end else begin
                  sum_nxt = sum_r + {8'h00, in_rx_byte};
                  pos_nxt = sfr_pkg::POS_MODE;
                end
              end
              sfr_pkg::POS_MODE: begin
                mode_nxt = in_rx_byte;
                sum_nxt  = sum_r + {8'h00, in_rx_byte};
                pos_nxt  = sfr_pkg::POS_OFFSET;
              end
              sfr_pkg::POS_OFFSET: begin
                offset_nxt = in_rx_byte;
                sum_nxt    = sum_r + {8'h00, in_rx_byte};
                pos_nxt    = sfr_pkg::POS_DATA;
              end
              default: begin
                if (k < PW'(data_cnt)) begin
                  wr_en   = 1'b1;
                  sum_nxt = sum_r + {8'h00, in_rx_byte};
                  pos_nxt = pos_eff + PW'(1);
                end else if (k == PW'(data_cnt)) begin
                  sum_lo_nxt = in_rx_byte;
                  pos_nxt    = pos_eff + PW'(1);
                end else begin
                  pos_nxt = sfr_pkg::POS_HUNT;
                  if (got_sum == ~sum_r) begin
                    state_nxt = sfr_pkg::ST_REPLAY;
                    iss_nxt   = '0;
                    emit_nxt  = '0;
                  end
                end
              end
            endcase
          end
        end
      end
      sfr_pkg::ST_REPLAY: begin
        if (data_cnt == '0) begin
          // A frame without data gives a single marker result.
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            o_len_nxt     = len_r;
            o_mode_nxt    = mode_r;
            o_offset_nxt  = offset_r;
            o_has_nxt     = 1'b0;
            o_idx_nxt     = '0;
            o_byte_nxt    = '0;
            o_last_nxt    = 1'b1;
            state_nxt     = sfr_pkg::ST_RECV;
          end
        end else begin
          // The read register holds its byte until the output slot takes it,
          // so the next read is issued only as the current one is consumed.
          consume = rd_pend_r && slot_free;
          rd_en   = (iss_r < data_cnt) && (!rd_pend_r || consume);
          if (rd_en) begin
            iss_nxt     = iss_r + CW'(1);
            rd_pend_nxt = 1'b1;
          end else if (consume) begin
            rd_pend_nxt = 1'b0;
          end
          if (consume) begin
            out_valid_nxt = 1'b1;
            o_len_nxt     = len_r;
            o_mode_nxt    = mode_r;
            o_offset_nxt  = offset_r;
            o_has_nxt     = 1'b1;
            o_idx_nxt     = emit_r[4:0];
            o_byte_nxt    = rd_data_r;
            o_last_nxt    = (emit_r + CW'(1)) == data_cnt;
            emit_nxt      = emit_r + CW'(1);
            if ((emit_r + CW'(1)) == data_cnt) begin
              state_nxt = sfr_pkg::ST_RECV;
            end
          end
        end
      end
      default: begin
        state_nxt = sfr_pkg::ST_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sfr_pkg::ST_RECV;
      pos_r       <= sfr_pkg::POS_HUNT;
      len_r       <= '0;
      mode_r      <= '0;
      offset_r    <= '0;
      sum_r       <= '0;
      sum_lo_r    <= '0;
      elapsed_r   <= '0;
      iss_r       <= '0;
      emit_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      mode_r      <= mode_nxt;
      offset_r    <= offset_nxt;
      sum_r       <= sum_nxt;
      sum_lo_r    <= sum_lo_nxt;
      elapsed_r   <= elapsed_nxt;
      iss_r       <= iss_nxt;
      emit_r      <= emit_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r <= sfr_pkg::OWN_ADDR_RST;
      timeout_r  <= sfr_pkg::TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sfr_pkg::CFG_OWN_ADDR: own_addr_r <= cfg_data[7:0];
        sfr_pkg::CFG_TIMEOUT:  timeout_r  <= cfg_data[TW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    o_len_r    <= o_len_nxt;
    o_mode_r   <= o_mode_nxt;
    o_offset_r <= o_offset_nxt;
    o_has_r    <= o_has_nxt;
    o_idx_r    <= o_idx_nxt;
    o_byte_r   <= o_byte_nxt;
    o_last_r   <= o_last_nxt;
  end

  // Writes happen only while receiving and reads only during replay, so the
  // two never touch the buffer in the same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[wr_addr] <= in_rx_byte;
    end
    if (rd_en) begin
      rd_data_r <= buf_mem[iss_r[AW-1:0]];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_length = o_len_r;
  assign out_frame_mode   = o_mode_r;
  assign out_frame_offset = o_offset_r;
  assign out_has_data     = o_has_r;
  assign out_byte_index   = o_idx_r;
  assign out_payload_byte = o_byte_r;
  assign out_last         = o_last_r;

endmodule

// ----- hw/rtl/sfr_checker.sv -----
// Port-level checks for the serial frame receiver, bound to the top level.
module sfr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_frame_length,
  input logic [7:0] out_frame_mode,
  input logic [7:0] out_frame_offset,
  input logic       out_has_data,
  input logic [4:0] out_byte_index,
  input logic [7:0] out_payload_byte,
  input logic       out_last
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_length) &&
      $stable(out_frame_mode) && $stable(out_frame_offset) &&
      $stable(out_has_data) && $stable(out_byte_index) &&
      $stable(out_payload_byte) && $stable(out_last))
    else $error("result changed while stalled");

  // A frame without data is a single result, so it must be the last one.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_data |-> out_last && (out_frame_length == 6'd2))
    else $error("empty frame result not marked last");

  // A data byte lies inside the frame's data.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_data |->
      (({1'b0, out_byte_index} + 6'd2) < out_frame_length))
    else $error("byte index beyond frame data");

  // The final data result sits at the end of the frame's data.
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_data && out_last |->
      (({1'b0, out_byte_index} + 6'd3) == out_frame_length))
    else $error("last flag on wrong byte");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind serial_frame_receiver_unit sfr_checker u_sfr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_frame_length (out_frame_length),
  .out_frame_mode   (out_frame_mode),
  .out_frame_offset (out_frame_offset),
  .out_has_data     (out_has_data),
  .out_byte_index   (out_byte_index),
  .out_payload_byte (out_payload_byte),
  .out_last         (out_last)
);

// ----- tb/serial_frame_receiver_unit_tb.sv -----
// Self-checking testbench for the serial frame receiver: framed traffic, timeouts, replay.
module serial_frame_receiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {
    FLAW_NONE,
    FLAW_HEADER,
    FLAW_LENGTH,
    FLAW_ADDRESS,
    FLAW_CHECKSUM,
    FLAW_TICKS
  } flaw_t;

  typedef struct packed {
    logic [sfr_pkg::LEN_W-1:0] frame_length;
    logic [7:0]                frame_mode;
    logic [7:0]                frame_offset;
    logic                      has_data;
    logic [sfr_pkg::IDX_W-1:0] byte_index;
    logic [7:0]                payload_byte;
    logic                      last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_command;
  logic [7:0] in_rx_byte;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] out_frame_length;
  logic [7:0] out_frame_mode;
  logic [7:0] out_frame_offset;
  logic out_has_data;
  logic [4:0] out_byte_index;
  logic [7:0] out_payload_byte;
  logic out_last;
  logic cfg_valid;
  logic cfg_ready;
  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data;

  // Receiver model state.
  logic [7:0]                 own_addr;
  logic [sfr_pkg::TICK_W-1:0] timeout_limit;
  logic [sfr_pkg::POS_W-1:0]  frame_pos;
  logic [7:0]                 len_q;
  logic [7:0]                 mode_q;
  logic [7:0]                 offset_q;
  logic [15:0]                sum_q;
  logic [7:0]                 sum_low_q;
  logic [sfr_pkg::TICK_W-1:0] tick_count;
  logic [7:0]                 data_store [sfr_pkg::MAX_DATA];

  frame_result_t pending_results[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int phase_requests = 0;

  serial_frame_receiver_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_length (out_frame_length),
    .out_frame_mode   (out_frame_mode),
    .out_frame_offset (out_frame_offset),
    .out_has_data     (out_has_data),
    .out_byte_index   (out_byte_index),
    .out_payload_byte (out_payload_byte),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic reset_receiver_model();
    own_addr      = sfr_pkg::OWN_ADDR_RST;
    timeout_limit = sfr_pkg::TIMEOUT_RST;
    frame_pos     = sfr_pkg::POS_HUNT;
    len_q         = '0;
    mode_q        = '0;
    offset_q      = '0;
    sum_q         = '0;
    sum_low_q     = '0;
    tick_count    = '0;
  endtask

  // Advances the receiver model by one accepted request and queues the
  // results that a good frame end replays.
  task automatic predict_request(input logic cmd, input logic [7:0] b);
    int data_count;
    int slot;
    frame_result_t res;
    if (cmd == sfr_pkg::CMD_TICK) begin
      if (tick_count != sfr_pkg::TICK_MAX) tick_count++;
      return;
    end
    if (frame_pos != sfr_pkg::POS_HUNT && tick_count >= timeout_limit) begin
      frame_pos = sfr_pkg::POS_HUNT;
    end
    case (frame_pos)
      sfr_pkg::POS_HUNT: begin
        if (b == sfr_pkg::HDR_FIRST) begin
          tick_count = '0;
          frame_pos = sfr_pkg::POS_HDR2;
        end
      end
      sfr_pkg::POS_HDR2: begin
        frame_pos = (b == sfr_pkg::HDR_SECOND) ? sfr_pkg::POS_LEN : sfr_pkg::POS_HUNT;
      end
      sfr_pkg::POS_LEN: begin
        if (b < sfr_pkg::MIN_LEN || int'(b) - 2 > sfr_pkg::MAX_DATA) begin
          frame_pos = sfr_pkg::POS_HUNT;
        end else begin
          len_q = b;
          sum_q = 16'(b);
          frame_pos = sfr_pkg::POS_ADDR;
        end
      end
      sfr_pkg::POS_ADDR: begin
        if (b != own_addr) begin
          frame_pos = sfr_pkg::POS_HUNT;
        end else begin
          sum_q += 16'(b);
          frame_pos = sfr_pkg::POS_MODE;
        end
      end
      sfr_pkg::POS_MODE: begin
        mode_q = b;
        sum_q += 16'(b);
        frame_pos = sfr_pkg::POS_OFFSET;
      end
      sfr_pkg::POS_OFFSET: begin
        offset_q = b;
        sum_q += 16'(b);
        frame_pos = sfr_pkg::POS_DATA;
      end
      default: begin
        data_count = int'(len_q) - 2;
        slot = int'(frame_pos) - int'(sfr_pkg::POS_DATA);
        if (slot < data_count) begin
          data_store[slot] = b;
          sum_q += 16'(b);
          frame_pos++;
        end else if (slot == data_count) begin
          sum_low_q = b;
          frame_pos++;
        end else begin
          frame_pos = sfr_pkg::POS_HUNT;
          if ({b, sum_low_q} == ~sum_q) begin
            res.frame_length = len_q[sfr_pkg::LEN_W-1:0];
            res.frame_mode   = mode_q;
            res.frame_offset = offset_q;
            if (data_count == 0) begin
              res.has_data     = 1'b0;
              res.byte_index   = '0;
              res.payload_byte = '0;
              res.last         = 1'b1;
              pending_results.push_back(res);
            end else begin
              for (int i = 0; i < data_count; i++) begin
                res.has_data     = 1'b1;
                res.byte_index   = sfr_pkg::IDX_W'(i);
                res.payload_byte = data_store[i];
                res.last         = (i + 1 == data_count);
                pending_results.push_back(res);
              end
            end
          end
        end
      end
    endcase
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no expectation pending");
      end else begin
        want = pending_results.pop_front();
        check_field("frame_length", int'(out_frame_length), int'(want.frame_length));
        check_field("frame_mode", int'(out_frame_mode), int'(want.frame_mode));
        check_field("frame_offset", int'(out_frame_offset), int'(want.frame_offset));
        check_field("has_data", int'(out_has_data), int'(want.has_data));
        check_field("byte_index", int'(out_byte_index), int'(want.byte_index));
        check_field("payload_byte", int'(out_payload_byte), int'(want.payload_byte));
        check_field("last", int'(out_last), int'(want.last));
      end
    end
  end

  always @(negedge clk) begin
    out_ready = (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no request accepted for %0d cycles", QUIET_LIMIT);
      $display("FAIL serial_frame_receiver_unit");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(input logic cmd, input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_command = cmd;
    in_rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(cmd, b);
    phase_requests++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_for_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                                input logic [sfr_pkg::CFG_DATA_W-1:0] value);
    wait_for_results();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == sfr_pkg::CFG_OWN_ADDR) begin
      own_addr = value[7:0];
    end else begin
      timeout_limit = value[sfr_pkg::TICK_W-1:0];
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_frame(input logic [7:0] mode, input logic [7:0] offs,
                            input logic [7:0] data[$], input flaw_t flaw);
    logic [8:0] seq[$];
    logic [15:0] sum;
    logic [7:0] len_byte;
    int n_ticks;
    len_byte = 8'(data.size() + 2);
    sum = 16'(len_byte) + 16'(own_addr) + 16'(mode) + 16'(offs);
    seq.push_back({sfr_pkg::CMD_BYTE, sfr_pkg::HDR_FIRST});
    seq.push_back({sfr_pkg::CMD_BYTE, sfr_pkg::HDR_SECOND});
    seq.push_back({sfr_pkg::CMD_BYTE, len_byte});
    seq.push_back({sfr_pkg::CMD_BYTE, own_addr});
    seq.push_back({sfr_pkg::CMD_BYTE, mode});
    seq.push_back({sfr_pkg::CMD_BYTE, offs});
    foreach (data[i]) begin
      seq.push_back({sfr_pkg::CMD_BYTE, data[i]});
      sum += 16'(data[i]);
    end
    sum = ~sum;
    seq.push_back({sfr_pkg::CMD_BYTE, sum[7:0]});
    seq.push_back({sfr_pkg::CMD_BYTE, sum[15:8]});
    case (flaw)
      FLAW_HEADER: begin
        // A repeated first header byte (or a random byte) replaces the second; it must not resync the hunt.
        seq[1] = {sfr_pkg::CMD_BYTE,
                  ($urandom_range(1) ? sfr_pkg::HDR_FIRST : 8'($urandom_range(255)))};
      end
      FLAW_LENGTH: begin
        case ($urandom_range(2))
          0: seq[2] = {sfr_pkg::CMD_BYTE, 8'd0};
          1: seq[2] = {sfr_pkg::CMD_BYTE, 8'd1};
          default: begin
            seq[2] = {sfr_pkg::CMD_BYTE, 8'($urandom_range(sfr_pkg::MAX_DATA + 3, 255))};
          end
        endcase
      end
      FLAW_ADDRESS: begin
        seq[3] = {sfr_pkg::CMD_BYTE, own_addr ^ 8'($urandom_range(1, 255))};
      end
      FLAW_CHECKSUM: begin
        seq[seq.size() - 1 - $urandom_range(1)][7:0] ^= 8'($urandom_range(1, 255));
      end
      FLAW_TICKS: begin
        n_ticks = $urandom_range(1, 4);
        repeat (n_ticks) begin
          seq.insert($urandom_range(1, seq.size() - 1), {sfr_pkg::CMD_TICK, 8'($urandom)});
        end
      end
      default: ;
    endcase
    foreach (seq[i]) send_request(seq[i][8], seq[i][7:0]);
  endtask

  task automatic test_directed_frames();
    logic [7:0] data[$];
    data = {};
    send_frame(8'h00, 8'h00, data, FLAW_NONE);
    data = {8'hFF};
    send_frame(8'hFF, 8'hFF, data, FLAW_NONE);
    // Length bytes just outside the legal range drop the frame early.
    send_request(sfr_pkg::CMD_BYTE, sfr_pkg::HDR_FIRST);
    send_request(sfr_pkg::CMD_BYTE, sfr_pkg::HDR_SECOND);
    send_request(sfr_pkg::CMD_BYTE, 8'd1);
    send_request(sfr_pkg::CMD_BYTE, sfr_pkg::HDR_FIRST);
    send_request(sfr_pkg::CMD_BYTE, sfr_pkg::HDR_SECOND);
    send_request(sfr_pkg::CMD_BYTE, 8'(sfr_pkg::MAX_DATA + 3));
    send_request(sfr_pkg::CMD_TICK, 8'hFF);
  endtask

  task automatic test_timeout();
    logic [7:0] data[$];
    data = {8'h12, 8'h34};
    write_register(sfr_pkg::CFG_TIMEOUT, 10'd3);
    // Two ticks stay below the limit, three reach it.
    send_request(sfr_pkg::CMD_BYTE, sfr_pkg::HDR_FIRST);
    send_request(sfr_pkg::CMD_TICK, 8'h00);
    send_request(sfr_pkg::CMD_TICK, 8'h00);
    send_frame(8'h01, 8'h02, data, FLAW_NONE);
    send_request(sfr_pkg::CMD_BYTE, sfr_pkg::HDR_FIRST);
    send_request(sfr_pkg::CMD_BYTE, sfr_pkg::HDR_SECOND);
    repeat (3) send_request(sfr_pkg::CMD_TICK, 8'h00);
    send_request(sfr_pkg::CMD_BYTE, 8'd4);
    send_frame(8'h03, 8'h04, data, FLAW_NONE);
    write_register(sfr_pkg::CFG_TIMEOUT, 10'd1);
    send_frame(8'h05, 8'h06, data, FLAW_TICKS);
    send_frame(8'h07, 8'h08, data, FLAW_NONE);
  endtask

  task automatic test_random_traffic(input logic [7:0] addr,
                                     input logic [sfr_pkg::TICK_W-1:0] limit,
                                     input int sender_pct, input int receiver_pct,
                                     input int n_requests);
    logic [7:0] data[$];
    int n_data;
    int pick;
    bit paused;
    flaw_t flaw;
    write_register(sfr_pkg::CFG_OWN_ADDR, sfr_pkg::CFG_DATA_W'(addr));
    write_register(sfr_pkg::CFG_TIMEOUT, sfr_pkg::CFG_DATA_W'(limit));
    send_idle_pct = sender_pct;
    stall_pct = receiver_pct;
    phase_requests = 0;
    paused = 0;
    while (phase_requests < n_requests) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        n_data = ($urandom_range(9) == 0) ? sfr_pkg::MAX_DATA : $urandom_range(6);
        data = {};
        repeat (n_data) data.push_back(8'($urandom));
        flaw = ($urandom_range(99) < 60) ? FLAW_NONE : flaw_t'($urandom_range(1, 5));
        send_frame(8'($urandom), 8'($urandom), data, flaw);
      end else if (pick < 85) begin
        send_request(sfr_pkg::CMD_BYTE, 8'($urandom));
      end else begin
        send_request(sfr_pkg::CMD_TICK, 8'($urandom));
      end
      if (!paused && phase_requests >= n_requests / 2) begin
        // Hold the sender until the replay queue has fully drained.
        wait_for_results();
        paused = 1;
      end
    end
    wait_for_results();
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_command = sfr_pkg::CMD_BYTE;
    in_rx_byte = '0;
    cfg_valid  = 1'b0;
    cfg_index  = sfr_pkg::CFG_OWN_ADDR;
    cfg_data   = '0;
    reset_receiver_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_frames();
    test_timeout();
    test_random_traffic(8'd34, 10'd100, 0, 0, 20);
    test_random_traffic(8'd0, 10'd1023, 58, 0, 20);
    test_random_traffic(8'd255, 10'd1, 0, 58, 20);
    test_random_traffic(8'($urandom), sfr_pkg::TICK_W'($urandom_range(1, 1023)), 26, 26, 20);

    wait_for_results();
    repeat (20) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS serial_frame_receiver_unit");
    end else begin
      $display("FAIL serial_frame_receiver_unit");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sfr_pkg.sv
hw/rtl/serial_frame_receiver_unit.sv
hw/rtl/sfr_checker.sv
tb/serial_frame_receiver_unit_tb.sv
